// File: rtl/gkh_pkg.sv
// Package for the glyph key lookup-or-insert table: sizes, hash, payload types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gkh_pkg;
   localparam int BUCKETS      = 256;
   localparam int POOL_ENTRIES = 1024;
   localparam int BKT_W  = $clog2(BUCKETS);
   localparam int IDX_W  = $clog2(POOL_ENTRIES);
   localparam int LINK_W = $clog2(POOL_ENTRIES + 1);
   localparam int KEY_W  = 62;
   localparam int QDEPTH = 2;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [20:0] char_code;
      logic [7:0]  size_px;
      logic [31:0] rgba_color;
      logic        outline;
   } req_type;

   typedef struct packed {
      logic [9:0] entry_index;
      logic       found;
      logic       full_res;
   } rsp_type;

   // Classified command passed from the front to the back
   typedef struct packed {
      logic             clear;
      logic [BKT_W-1:0] bucket;
      logic [KEY_W-1:0] key;
   } cmd_type;

   function automatic logic [BKT_W-1:0] bucket_of(input req_type r);
      logic [31:0] v;
      v = {11'd0, r.char_code} ^ (32'(r.size_px) * 32'd97) ^ r.rgba_color
          ^ (r.outline ? 32'd31 : 32'd0);
      return v[BKT_W-1:0];
   endfunction

   function automatic logic [KEY_W-1:0] key_of(input req_type r);
      return {r.outline, r.rgba_color, r.size_px, r.char_code};
   endfunction
endpackage
`default_nettype wire

// File: rtl/gkh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module gkh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: rtl/gkh_front.sv
// Front end: accepts transactions, hashes the key and queues commands.
// Depends on gkh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gkh_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_push,
   output logic                 req_full,
   input  wire gkh_pkg::req_type req_data,
   output logic                 cmd_valid,
   output gkh_pkg::cmd_type     cmd_data,
   input  wire logic            cmd_take
);
   import gkh_pkg::*;
   localparam int PTR_W = $clog2(QDEPTH);

   cmd_type          q_ff [QDEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [PTR_W:0]   cnt_ff;
   logic             push_ok;
   cmd_type          cmd_in;

   assign req_full  = (cnt_ff == (PTR_W+1)'(QDEPTH));
   assign push_ok   = req_push && !req_full;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd_data  = q_ff[rd_ff];

   // Classify the incoming transaction
   always_comb begin
      cmd_in.clear  = (req_data.operation == OP_CLEAR);
      cmd_in.bucket = bucket_of(req_data);
      cmd_in.key    = key_of(req_data);
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push_ok) q_ff[wr_ff] <= cmd_in;
   end

   // Queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push_ok) wr_ff <= wr_ff + 1'b1;
         if (cmd_take) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (PTR_W+1)'(push_ok) - (PTR_W+1)'(cmd_take);
      end
   end
endmodule
`default_nettype wire

// File: rtl/gkh_back.sv
// Back end: walks bucket chains, inserts new keys, clears the table.
// Depends on gkh_pkg and gkh_ram.
`timescale 1ns / 1ps
`default_nettype none
module gkh_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            cmd_valid,
   input  wire gkh_pkg::cmd_type cmd_data,
   output logic                 cmd_take,
   output logic                 rsp_empty,
   input  wire logic            rsp_pop,
   output gkh_pkg::rsp_type     rsp_data
);
   import gkh_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CLEAR, ST_HEAD, ST_ENTRY, ST_CHECK, ST_DONE, ST_WIPE
   } state_type;

   state_type         state_ff;
   cmd_type           cmd_ff;
   logic [BKT_W-1:0]  clr_ff;
   logic [LINK_W-1:0] free_ff, link_ff, head_ff;
   logic [LINK_W:0]   steps_ff;
   logic              hit_ff;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;

   // Memory ports
   logic              hd_we, en_we;
   logic [BKT_W-1:0]  hd_wa, hd_ra;
   logic [LINK_W-1:0] hd_wd, hd_rd, ln_rd;
   logic [IDX_W-1:0]  en_wa, en_ra;
   logic [KEY_W-1:0]  key_rd;
   logic              can_insert;

   gkh_ram #(.WIDTH(LINK_W), .DEPTH(BUCKETS)) u_head (
      .clock, .wr_en(hd_we), .wr_addr(hd_wa), .wr_data(hd_wd),
      .rd_addr(hd_ra), .rd_data(hd_rd));
   gkh_ram #(.WIDTH(KEY_W), .DEPTH(POOL_ENTRIES)) u_key (
      .clock, .wr_en(en_we), .wr_addr(en_wa), .wr_data(cmd_ff.key),
      .rd_addr(en_ra), .rd_data(key_rd));
   gkh_ram #(.WIDTH(LINK_W), .DEPTH(POOL_ENTRIES)) u_link (
      .clock, .wr_en(en_we), .wr_addr(en_wa), .wr_data(head_ff),
      .rd_addr(en_ra), .rd_data(ln_rd));

   assign cmd_take   = (state_ff == ST_IDLE) && cmd_valid;
   assign rsp_empty  = !rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign can_insert = (free_ff < LINK_W'(POOL_ENTRIES));
   // Read the head of the incoming command's bucket on the edge that takes it
   assign hd_ra      = (state_ff == ST_IDLE) ? cmd_data.bucket : cmd_ff.bucket;
   assign en_ra      = (state_ff == ST_HEAD) ? IDX_W'(hd_rd - 1'b1)
                                             : IDX_W'(link_ff - 1'b1);
   assign en_wa      = IDX_W'(free_ff);

   // Memory writes: clearing sweep or insert at the chain head
   always_comb begin
      hd_we = 1'b0;
      en_we = 1'b0;
      hd_wa = cmd_ff.bucket;
      hd_wd = free_ff + 1'b1;
      if (state_ff == ST_CLEAR || state_ff == ST_WIPE) begin
         hd_we = 1'b1;
         hd_wa = clr_ff;
         hd_wd = '0;
      end else if (state_ff == ST_DONE && !rsp_valid_ff && !cmd_ff.clear && !hit_ff
                   && can_insert) begin
         hd_we = 1'b1;
         en_we = 1'b1;
      end
   end

   // Sequencer: HEAD reads the bucket, ENTRY reads an entry, CHECK compares it
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         free_ff      <= '0;
      end else begin
         if (rsp_pop && rsp_valid_ff) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_WIPE: begin
               // Empty every bucket once after reset
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == BKT_W'(BUCKETS - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff   <= cmd_data;
                  clr_ff   <= '0;
                  steps_ff <= '0;
                  hit_ff   <= 1'b0;
                  state_ff <= cmd_data.clear ? ST_CLEAR : ST_HEAD;
               end
            end
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == BKT_W'(BUCKETS - 1)) begin
                  free_ff  <= '0;
                  state_ff <= ST_DONE;
               end
            end
            ST_HEAD: begin
               // hd_rd is now valid
               head_ff <= hd_rd;
               link_ff <= hd_rd;
               if (hd_rd == '0) state_ff <= ST_DONE;
               else state_ff <= ST_ENTRY;
            end
            ST_ENTRY: state_ff <= ST_CHECK;
            ST_CHECK: begin
               steps_ff <= steps_ff + 1'b1;
               if (key_rd == cmd_ff.key) begin
                  hit_ff   <= 1'b1;
                  state_ff <= ST_DONE;
               end else if (ln_rd == '0 || ln_rd > LINK_W'(POOL_ENTRIES)
                            || steps_ff + 1'b1 >= (LINK_W+1)'(POOL_ENTRIES)) begin
                  state_ff <= ST_DONE;
               end else begin
                  link_ff  <= ln_rd;
                  state_ff <= ST_ENTRY;
               end
            end
            ST_DONE: begin
               // Once the slot is free, insert on a miss if the pool has room and present the result
               if (!rsp_valid_ff) begin
                  if (cmd_ff.clear) begin
                     rsp_ff <= '0;
                  end else if (hit_ff) begin
                     rsp_ff.entry_index <= 10'(link_ff - 1'b1);
                     rsp_ff.found       <= 1'b1;
                     rsp_ff.full_res    <= 1'b0;
                  end else begin
                     rsp_ff.found <= 1'b0;
                     if (can_insert) begin
                        rsp_ff.entry_index <= 10'(free_ff);
                        rsp_ff.full_res    <= 1'b0;
                        free_ff            <= free_ff + 1'b1;
                     end else begin
                        rsp_ff.entry_index <= '0;
                        rsp_ff.full_res    <= 1'b1;
                     end
                  end
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// File: rtl/glyph_key_hash_lookup_insert.sv
// Top level of the glyph key lookup-or-insert table.
// Depends on gkh_pkg, gkh_front, gkh_back.
//
// Usage: push a transaction on req_ while req_full is low; each gives exactly
// one result on rsp_, shown while rsp_empty is low and taken with rsp_pop.
// A lookup hashes the key, reads the bucket head, then walks the chain entry by
// entry (registered read, then compare); a hit returns found=1, a miss
// inserts at the chain head from a bump pointer. The length of the chain
// walk sets the rate. A clear sweeps the bucket heads one a cycle.
// A two-entry command queue parts the front from the back so pushes continue
// while the back works. If the receiver stalls, the back holds its finished
// result and the queue fills, then req_full rises. Reset empties the queue
// and result slot, zeroes the pool pointer and sweeps the bucket heads to
// empty, one a cycle, and takes the first command once the sweep is done;
// the queue still takes two transactions during the sweep.
`timescale 1ns / 1ps
`default_nettype none
module glyph_key_hash_lookup_insert (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire gkh_pkg::req_type req_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output gkh_pkg::rsp_type      rsp_data
);
   import gkh_pkg::*;

   logic    cmd_valid, cmd_take;
   cmd_type cmd_data;

   gkh_front u_front (
      .clock, .reset, .req_push, .req_full, .req_data,
      .cmd_valid, .cmd_data, .cmd_take);

   gkh_back u_back (
      .clock, .reset, .cmd_valid, .cmd_data, .cmd_take,
      .rsp_empty, .rsp_pop, .rsp_data);
endmodule
`default_nettype wire

// File: rtl/gkh_checker.sv
// Port-level checker for the glyph key table, bound to the top level.
// Depends on gkh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gkh_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_full,
   input wire logic             rsp_empty,
   input wire logic             rsp_pop,
   input wire gkh_pkg::rsp_type rsp_data
);
   // A result waiting and not popped holds its value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("result changed while stalled");
   // Found and full are never set together
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> !(rsp_data.found && rsp_data.full_res))
      else $error("found and full both set");
   // A full result carries index zero
   a_fullidx: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.full_res) |-> (rsp_data.entry_index == '0))
      else $error("full result with nonzero index");
   // After reset the result side is empty and input open
   a_rst: assert property (@(posedge clock) reset |=> (rsp_empty && !req_full))
      else $error("not empty after reset");
endmodule

bind glyph_key_hash_lookup_insert gkh_checker u_chk (
   .clock, .reset, .req_full, .rsp_empty, .rsp_pop, .rsp_data);
`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for glyph_key_hash_lookup_insert: directed table, then random traffic.
// Holds its own chained-table predictor. Depends on gkh_pkg and the RTL top level.
`timescale 1ns / 1ps
module testbench;
   import gkh_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 300;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   glyph_key_hash_lookup_insert DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // Predictor state of the glyph table
   int unsigned      chain_head [BUCKETS];
   logic [KEY_W-1:0] pool_key [POOL_ENTRIES];
   int unsigned      pool_link [POOL_ENTRIES];
   int unsigned      bump_ptr;

   rsp_type    pending_lookups[$];
   req_type    recent_glyphs[$];
   int         errors = 0;
   int         cycles = 0;
   int         snd_idle_pct = 0;
   int         rcv_idle_pct = 0;
   int         stall_asked = 0;
   int         stall_served = 0;
   int         stall_left = 0;

   typedef struct {
      req_type   item;
      bit        typed;
      rsp_type   answer;
   } table_row;
   table_row glyph_table[$];

   // Compute the result of one transaction and advance the table state
   function automatic rsp_type lookup_glyph(req_type r);
      rsp_type          res;
      logic [31:0]      mix;
      logic [KEY_W-1:0] k;
      int unsigned      b, link, steps, idx;
      res = '0;
      if (r.operation == OP_CLEAR) begin
         foreach (chain_head[i]) chain_head[i] = 0;
         bump_ptr = 0;
         return res;
      end
      mix = {11'd0, r.char_code} ^ (32'(r.size_px) * 32'd97) ^ r.rgba_color
            ^ (r.outline ? 32'd31 : 32'd0);
      b = mix % BUCKETS;
      k = {r.outline, r.rgba_color, r.size_px, r.char_code};
      link = chain_head[b];
      steps = 0;
      while (link != 0 && link <= POOL_ENTRIES && steps < POOL_ENTRIES) begin
         idx = link - 1;
         if (pool_key[idx] == k) begin
            res.entry_index = idx[9:0];
            res.found = 1'b1;
            return res;
         end
         link = pool_link[idx];
         steps++;
      end
      if (bump_ptr >= POOL_ENTRIES) begin
         res.full_res = 1'b1;
         return res;
      end
      idx = bump_ptr;
      pool_key[idx] = k;
      pool_link[idx] = chain_head[b];
      chain_head[b] = idx + 1;
      bump_ptr = idx + 1;
      res.entry_index = idx[9:0];
      return res;
   endfunction

   function automatic req_type glyph(logic op, logic [20:0] c, logic [7:0] s,
                                     logic [31:0] col, logic o);
      req_type r;
      r.operation = op;
      r.char_code = c;
      r.size_px = s;
      r.rgba_color = col;
      r.outline = o;
      return r;
   endfunction

   function automatic rsp_type answer(int unsigned idx, logic f);
      rsp_type a;
      a.entry_index = idx[9:0];
      a.found = f;
      a.full_res = 1'b0;
      return a;
   endfunction

   // Random key: fresh full-range fields, or a recently used key to provoke hits
   function automatic req_type random_glyph(int reuse_pct);
      req_type r;
      if (recent_glyphs.size() > 0 && $urandom_range(99) < reuse_pct)
         return recent_glyphs[$urandom_range(recent_glyphs.size() - 1)];
      r = glyph(OP_LOOKUP, 21'($urandom), 8'($urandom), $urandom, 1'($urandom));
      case ($urandom_range(7))
         0: r.char_code = '1;
         1: r.size_px = '0;
         2: r.rgba_color = '1;
         3: r.char_code = 21'($urandom_range(255));
         default: ;
      endcase
      recent_glyphs.push_back(r);
      if (recent_glyphs.size() > 64) void'(recent_glyphs.pop_front());
      return r;
   endfunction

   // Offer one transaction; return after the edge that accepts it, or after a random idle gap that follows it
   task automatic send_glyph(req_type r, bit typed = 1'b0, rsp_type want = '0);
      rsp_type p;
      req_push <= 1'b1;
      req_data <= r;
      @(negedge clock);
      while (req_full) @(negedge clock);
      p = lookup_glyph(r);
      pending_lookups.push_back(typed ? want : p);
      @(posedge clock);
      if ($urandom_range(99) < snd_idle_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
   endtask

   // Mixed random traffic: mostly keys, some repeats, rare clears
   task automatic random_traffic(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 2)
            send_glyph(glyph(OP_CLEAR, 21'($urandom), 8'($urandom), $urandom, 1'($urandom)));
         else
            send_glyph(random_glyph(45));
      end
   endtask

   // Cycle count and run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Drive pop; serve long hold-off requests by counting cycles here
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_pop <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_asked != stall_served) begin
         rsp_pop <= 1'b0;
         stall_left <= 600;
         stall_served <= stall_served + 1;
      end else begin
         rsp_pop <= !reset && ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // Check each result transaction against the oldest expectation
   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_lookups.size() == 0) begin
            $error("unexpected result: entry_index %0d found %0b full_res %0b",
                   rsp_data.entry_index, rsp_data.found, rsp_data.full_res);
            errors++;
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_data.entry_index !== want.entry_index) begin
               $error("entry_index: expected %0d, got %0d", want.entry_index,
                      rsp_data.entry_index);
               errors++;
            end
            if (rsp_data.found !== want.found) begin
               $error("found: expected %0b, got %0b", want.found, rsp_data.found);
               errors++;
            end
            if (rsp_data.full_res !== want.full_res) begin
               $error("full_res: expected %0b, got %0b", want.full_res, rsp_data.full_res);
               errors++;
            end
         end
      end
   end

   initial begin
      req_type k;
      foreach (chain_head[i]) chain_head[i] = 0;
      bump_ptr = 0;

      // Directed table: a clear, then inserts, hits and walks down a shared chain
      glyph_table.push_back('{glyph(OP_CLEAR, 0, 0, 0, 0), 1, answer(0, 0)});
      glyph_table.push_back('{glyph(OP_LOOKUP, '1, '1, '1, 1), 1, answer(0, 0)});
      glyph_table.push_back('{glyph(OP_LOOKUP, '1, '1, '1, 1), 1, answer(0, 1)});
      glyph_table.push_back('{glyph(OP_LOOKUP, 0, 0, 0, 0), 1, answer(1, 0)});
      glyph_table.push_back('{glyph(OP_LOOKUP, 0, 0, 0, 0), 1, answer(1, 1)});
      glyph_table.push_back('{glyph(OP_LOOKUP, 0, 0, 0, 1), 1, answer(2, 0)});
      // Three keys sharing bucket one, then hits that walk past the head
      glyph_table.push_back('{glyph(OP_LOOKUP, 1, 0, 0, 0), 1, answer(3, 0)});
      glyph_table.push_back('{glyph(OP_LOOKUP, 257, 0, 0, 0), 1, answer(4, 0)});
      glyph_table.push_back('{glyph(OP_LOOKUP, 1, 0, 0, 0), 1, answer(3, 1)});
      glyph_table.push_back('{glyph(OP_LOOKUP, 513, 0, 0, 0), 1, answer(5, 0)});
      glyph_table.push_back('{glyph(OP_LOOKUP, 257, 0, 0, 0), 1, answer(4, 1)});
      glyph_table.push_back('{glyph(OP_LOOKUP, 0, 8'hFF, 0, 0), 0, '0});
      glyph_table.push_back('{glyph(OP_LOOKUP, 0, 0, 32'h8000_0000, 0), 0, '0});
      glyph_table.push_back('{glyph(OP_LOOKUP, 21'h100000, 1, 32'h00FF_00FF, 1), 0, '0});
      glyph_table.push_back('{glyph(OP_LOOKUP, 21'h0ABCDE, 8'h55, 32'hDEAD_BEEF, 0), 0, '0});
      glyph_table.push_back('{glyph(OP_CLEAR, '1, '1, '1, 1), 1, answer(0, 0)});
      glyph_table.push_back('{glyph(OP_LOOKUP, 1, 0, 0, 0), 1, answer(0, 0)});
      glyph_table.push_back('{glyph(OP_LOOKUP, '1, '1, '1, 1), 1, answer(1, 0)});
      glyph_table.push_back('{glyph(OP_LOOKUP, 1, 0, 0, 0), 1, answer(0, 1)});

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (glyph_table[i])
         send_glyph(glyph_table[i].item, glyph_table[i].typed, glyph_table[i].answer);

      // Hold the sender until every result is back
      wait_drained();
      @(posedge clock);

      // Phase one: light sender gaps, heavy receiver stalls, one long hold-off
      snd_idle_pct = 15;
      rcv_idle_pct = 49;
      random_traffic(200);
      stall_asked = stall_asked + 1;
      random_traffic(250);

      // Phase two: exhaust the pool, then mix hits with misses that find it full
      snd_idle_pct = 49;
      rcv_idle_pct = 15;
      send_glyph(glyph(OP_CLEAR, 0, 0, 0, 0));
      recent_glyphs.delete();
      for (int i = 0; i < POOL_ENTRIES + 4; i++) begin
         k = glyph(OP_LOOKUP, 21'($urandom), 8'($urandom), $urandom, 1'($urandom));
         if (i % 16 == 0) begin
            recent_glyphs.push_back(k);
            if (recent_glyphs.size() > 64) void'(recent_glyphs.pop_front());
         end
         send_glyph(k);
      end
      for (int i = 0; i < 40; i++) send_glyph(random_glyph(50));
      send_glyph(glyph(OP_CLEAR, 0, 0, 0, 0));
      random_traffic(150);

      // Phase three: no idling on either side
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      random_traffic(250);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule

// File: filelist.f
rtl/gkh_pkg.sv
rtl/gkh_ram.sv
rtl/gkh_front.sv
rtl/gkh_back.sv
rtl/glyph_key_hash_lookup_insert.sv
rtl/gkh_checker.sv
dv/testbench.sv
